// ===== rtl/core/ebht_pkg.sv =====
// ----------------------------------------------------------------------------
// ebht_pkg
// Shared widths, codes and types of the elliptic bubble hit test block.
// ----------------------------------------------------------------------------
package ebht_pkg;

   localparam int MODE_W   = 2;
   localparam int POS_W    = 24;
   localparam int RAD_W    = 23;
   localparam int STR_W    = 16;
   localparam int SLOT_W   = 6;

   // shared multiplier: 24 x 32 unsigned
   localparam int MUL_A_W  = 24;
   localparam int MUL_B_W  = 32;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTWARD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL  = 1'b1;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PROBE = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic        [RAD_W-1:0] rad;
      logic        [STR_W-1:0] str;
   } entry_type;

endpackage

// ===== rtl/core/ebht_if.sv =====
// ----------------------------------------------------------------------------
// ebht channels
// Valid/ready channels for requests and responses of the hit test block.
// ----------------------------------------------------------------------------
interface ebht_req_if;
   logic                            valid;
   logic                            ready;
   logic [ebht_pkg::MODE_W-1:0]     mode;
   logic signed [ebht_pkg::POS_W-1:0] pos_x;
   logic signed [ebht_pkg::POS_W-1:0] pos_y;
   logic [ebht_pkg::RAD_W-1:0]      radius;
   logic [ebht_pkg::STR_W-1:0]      stretch;

   modport source (output valid, mode, pos_x, pos_y, radius, stretch, input ready);
   modport sink   (input valid, mode, pos_x, pos_y, radius, stretch, output ready);
endinterface

interface ebht_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic [ebht_pkg::SLOT_W-1:0]     slot;
   logic                            status;

   modport source (output valid, hit, slot, status, input ready);
   modport sink   (input valid, hit, slot, status, output ready);
endinterface

// ===== rtl/core/ebht_store.sv =====
// ----------------------------------------------------------------------------
// ebht_store
// Bubble table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ebht_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  ebht_pkg::entry_type wr_entry,
   input  logic [ADDR_W-1:0]   rd_addr,
   output ebht_pkg::entry_type rd_entry
);
   import ebht_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff <= mem_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== rtl/core/ebht_mul.sv =====
// ----------------------------------------------------------------------------
// ebht_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ebht_mul (
   input  logic                          clock,
   input  logic [ebht_pkg::MUL_A_W-1:0]  op_a,
   input  logic [ebht_pkg::MUL_B_W-1:0]  op_b,
   output logic [ebht_pkg::MUL_P_W-1:0]  prod
);
   import ebht_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/elliptic_bubble_hit_test.sv =====
// ----------------------------------------------------------------------------
// elliptic_bubble_hit_test
// Table of elliptic bubbles with add, point test and probe radius test.
// ----------------------------------------------------------------------------
//  channel    direction  carries
//  req_chan   in         mode, pos_x, pos_y, radius, stretch
//  rsp_chan   out        hit, slot, status
//  csr_*      in         outward_mode (index 0), global_mode (index 1)
//
//  an add, an unused mode, a global-mode test or a test on an empty table
//  goes from idle through the finish state to the response register
//  a test passes through load, the six multiplier states and compare
//  for each bubble checked, making six passes through the one shared multiplier
//  reset clears the bubble count, the mode registers and the response valid
//  a new request is taken while an earlier response still waits
// ----------------------------------------------------------------------------
module elliptic_bubble_hit_test #(
   parameter int MAX_BUBBLES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   ebht_req_if.sink                          req_chan,
   ebht_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [ebht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ebht_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ebht_pkg::*;

   localparam int IDX_W = (MAX_BUBBLES > 1) ? $clog2(MAX_BUBBLES) : 1;
   localparam int CNT_W = $clog2(MAX_BUBBLES + 1);
   localparam int SUM_W = MUL_P_W + 1;
   localparam int SQ_W  = 2 * MUL_A_W;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_LOAD   = 10'b00_0000_0010,
      ST_MUL_R  = 10'b00_0000_0100,
      ST_MUL_DX = 10'b00_0000_1000,
      ST_MUL_DY = 10'b00_0001_0000,
      ST_MUL_E  = 10'b00_0010_0000,
      ST_MUL_LO = 10'b00_0100_0000,
      ST_MUL_HI = 10'b00_1000_0000,
      ST_CMP    = 10'b01_0000_0000,
      ST_FINISH = 10'b10_0000_0000
   } state_type;

   // control registers
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               outward_ff, outward_in;
   logic               global_ff, global_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // pending result
   logic               res_hit_ff, res_hit_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic               res_status_ff, res_status_in;

   // response payload
   logic               rsp_hit_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic               rsp_status_ff;

   // search datapath
   logic signed [POS_W-1:0] px_ff, py_ff;
   logic [RAD_W-1:0]   probe_ff;
   logic [MUL_A_W-1:0] r_ff, dx_ff, dy_ff;
   logic [STR_W-1:0]   e_ff;
   logic [SQ_W-1:0]    r2_ff, dx2_ff, dy2_ff, diff_ff;
   logic [MUL_B_W-1:0] e2_ff;
   logic               miss_ff;
   logic [MUL_P_W-1:0] lo_ff;

   logic               req_acc;
   logic               rsp_free;
   logic               full;
   logic               last;
   logic               found;
   logic [SUM_W-1:0]   sum;
   logic [POS_W:0]     dx_raw, dy_raw, dx_neg, dy_neg;

   logic               wr_en;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          wr_entry, rd_entry;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;

   ebht_store #(
      .DEPTH  (MAX_BUBBLES),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (cnt_ff[IDX_W-1:0]),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   ebht_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign full           = (cnt_ff == CNT_W'(MAX_BUBBLES));
   assign last           = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);

   assign wr_entry.x   = req_chan.pos_x;
   assign wr_entry.y   = req_chan.pos_y;
   assign wr_entry.rad = req_chan.radius;
   assign wr_entry.str = req_chan.stretch;
   assign wr_en        = req_acc && (req_chan.mode == MODE_ADD) && !full;

   // lo + hi * 2^24 > dy2 * 2^24, folded down to the upper product bits
   assign sum   = SUM_W'(prod) + SUM_W'(lo_ff[MUL_P_W-1:24])
                + SUM_W'(lo_ff[23:0] != '0);
   assign found = !miss_ff && (sum > SUM_W'(dy2_ff));

   // absolute centre offsets
   assign dx_raw = {px_ff[POS_W-1], px_ff} - {rd_entry.x[POS_W-1], rd_entry.x};
   assign dy_raw = {py_ff[POS_W-1], py_ff} - {rd_entry.y[POS_W-1], rd_entry.y};
   assign dx_neg = '0 - dx_raw;
   assign dy_neg = '0 - dy_raw;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_R: begin
            mul_a = r_ff;
            mul_b = MUL_B_W'(r_ff);
         end
         ST_MUL_DX: begin
            mul_a = dx_ff;
            mul_b = MUL_B_W'(dx_ff);
         end
         ST_MUL_DY: begin
            mul_a = dy_ff;
            mul_b = MUL_B_W'(dy_ff);
         end
         ST_MUL_E: begin
            mul_a = MUL_A_W'(e_ff);
            mul_b = MUL_B_W'(e_ff);
         end
         ST_MUL_LO: begin
            mul_a = diff_ff[23:0];
            mul_b = prod[MUL_B_W-1:0];
         end
         ST_MUL_HI: begin
            mul_a = diff_ff[SQ_W-1:24];
            mul_b = e2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      res_hit_in    = res_hit_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rd_addr       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               res_hit_in    = 1'b0;
               res_slot_in   = '0;
               res_status_in = 1'b0;
               idx_in        = '0;
               state_in      = ST_FINISH;
               case (req_chan.mode) inside
                  MODE_ADD: begin
                     if (full) begin
                        res_status_in = 1'b1;
                     end else begin
                        res_slot_in = SLOT_W'(cnt_ff);
                        cnt_in      = cnt_ff + CNT_W'(1);
                     end
                  end
                  MODE_POINT, MODE_PROBE: begin
                     if (global_ff) begin
                        res_hit_in = !outward_ff;
                     end else if (cnt_ff == '0) begin
                        res_hit_in = outward_ff;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                     res_hit_in = 1'b0;
                  end
               endcase
            end
         end
         ST_LOAD:   state_in = ST_MUL_R;
         ST_MUL_R:  state_in = ST_MUL_DX;
         ST_MUL_DX: state_in = ST_MUL_DY;
         ST_MUL_DY: state_in = ST_MUL_E;
         ST_MUL_E:  state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_CMP;
         ST_CMP: begin
            rd_addr = idx_ff + IDX_W'(1);
            if (found) begin
               res_hit_in = !outward_ff;
               state_in   = ST_FINISH;
            end else if (last) begin
               res_hit_in = outward_ff;
               state_in   = ST_FINISH;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      outward_in = outward_ff;
      global_in  = global_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OUTWARD: outward_in = csr_wdata[0];
            CSR_GLOBAL:  global_in  = csr_wdata[0];
            default:     outward_in = outward_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         outward_ff   <= 1'b0;
         global_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         outward_ff   <= outward_in;
         global_ff    <= global_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_hit_ff    <= res_hit_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_hit_ff    <= res_hit_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
      end
      if (req_acc) begin
         px_ff    <= req_chan.pos_x;
         py_ff    <= req_chan.pos_y;
         probe_ff <= (req_chan.mode == MODE_PROBE) ? req_chan.radius : '0;
      end
      if (state_ff == ST_LOAD) begin
         r_ff  <= MUL_A_W'(rd_entry.rad) + MUL_A_W'(probe_ff);
         dx_ff <= dx_raw[POS_W] ? dx_neg[MUL_A_W-1:0] : dx_raw[MUL_A_W-1:0];
         dy_ff <= dy_raw[POS_W] ? dy_neg[MUL_A_W-1:0] : dy_raw[MUL_A_W-1:0];
         e_ff  <= rd_entry.str;
      end
      if (state_ff == ST_MUL_DX) begin
         r2_ff <= prod[SQ_W-1:0];
      end
      if (state_ff == ST_MUL_DY) begin
         dx2_ff <= prod[SQ_W-1:0];
      end
      if (state_ff == ST_MUL_E) begin
         dy2_ff  <= prod[SQ_W-1:0];
         diff_ff <= r2_ff - dx2_ff;
         miss_ff <= (r2_ff <= dx2_ff);
      end
      if (state_ff == ST_MUL_LO) begin
         e2_ff <= prod[MUL_B_W-1:0];
      end
      if (state_ff == ST_MUL_HI) begin
         lo_ff <= prod;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.hit    = rsp_hit_ff;
   assign rsp_chan.slot   = rsp_slot_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule

// ===== rtl/core/ebht_check.sv =====
// ----------------------------------------------------------------------------
// ebht_check
// Port-level checks of the hit test block, bound to the top level.
// ----------------------------------------------------------------------------
module ebht_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_hit,
   input logic [ebht_pkg::SLOT_W-1:0]   rsp_slot,
   input logic                          rsp_status
);
   import ebht_pkg::*;

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // a refused add carries nothing else
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_hit && rsp_slot == '0)
      else $error("refused add with hit or slot");

   // a hit comes only from a test, which has no slot and no error
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_slot == '0 && !rsp_status)
      else $error("hit response with slot or status");

   // the block is busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a request");

endmodule

bind elliptic_bubble_hit_test ebht_check u_ebht_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_hit    (rsp_chan.hit),
   .rsp_slot   (rsp_chan.slot),
   .rsp_status (rsp_chan.status)
);
